@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define TCCE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TCCE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tcce_pkg.sv @@
`timescale 1ns / 1ps

package tcce_pkg;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CK_PLAIN,
      CK_NEWLINE,
      CK_RETURN,
      CK_TAB,
      CK_BACK
   } char_kind_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_TAB,
      ST_COPY,
      ST_DRAIN,
      ST_FILL,
      ST_CLEAR,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_CAPTURE,
      DP_INIT,
      DP_PLAIN_CHAR,
      DP_PLAIN_SPACE,
      DP_BACK,
      DP_RETURN,
      DP_NEWROW,
      DP_COPY,
      DP_DRAIN,
      DP_FILL,
      DP_CLEAR,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type    opcode;
      char_kind_type kind;
      logic          wrap;
      logic          row_last;
      logic          sweep_last;
      logic          copy_last;
      logic          tab_last;
      logic          tab_zero;
      logic          rsp_free;
   } dp_status_type;

   localparam logic [7:0]  CH_NEWLINE = 8'h0A;
   localparam logic [7:0]  CH_RETURN  = 8'h0D;
   localparam logic [7:0]  CH_TAB     = 8'h09;
   localparam logic [7:0]  CH_BACK    = 8'h08;
   localparam logic [7:0]  CH_SPACE   = 8'h20;
   localparam logic [2:0]  TAB_STOP   = 3'd4;
   localparam logic [7:0]  ATTR_RESET = 8'h07;
   localparam logic [15:0] INIT_CELL  = 16'h0720;

endpackage

@@ design/tcce_ctrl.sv @@
`timescale 1ns / 1ps

module tcce_ctrl
   import tcce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = DP_IDLE;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_INIT: begin
            cmd.op = DP_INIT;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_CAPTURE;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.opcode)
               OP_PUT: begin
                  unique case (status.kind)
                     CK_NEWLINE: begin
                        cmd.op   = DP_NEWROW;
                        state_in = status.row_last ? ST_COPY : ST_FINISH;
                     end
                     CK_RETURN: begin
                        cmd.op   = DP_RETURN;
                        state_in = ST_FINISH;
                     end
                     CK_BACK: begin
                        cmd.op   = DP_BACK;
                        state_in = ST_FINISH;
                     end
                     CK_TAB: begin
                        cmd.op = DP_PLAIN_SPACE;
                        if (status.wrap && status.row_last) state_in = ST_COPY;
                        else if (status.tab_last)           state_in = ST_FINISH;
                        else                                state_in = ST_TAB;
                     end
                     default: begin
                        cmd.op   = DP_PLAIN_CHAR;
                        state_in = (status.wrap && status.row_last) ? ST_COPY : ST_FINISH;
                     end
                  endcase
               end
               OP_CLEAR: state_in = ST_CLEAR;
               default:  state_in = ST_FINISH;
            endcase
         end
         ST_TAB: begin
            cmd.op = DP_PLAIN_SPACE;
            if (status.wrap && status.row_last) state_in = ST_COPY;
            else if (status.tab_last)           state_in = ST_FINISH;
         end
         ST_COPY: begin
            cmd.op = DP_COPY;
            if (status.copy_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.op   = DP_DRAIN;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.op = DP_FILL;
            if (status.sweep_last) begin
               // resume a tab whose spaces ran past the bottom row
               if (status.opcode == OP_PUT && status.kind == CK_TAB && !status.tab_zero)
                  state_in = ST_TAB;
               else
                  state_in = ST_FINISH;
            end
         end
         ST_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (status.sweep_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.op   = DP_FINISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

endmodule

@@ design/tcce_datapath.sv @@
`timescale 1ns / 1ps

module tcce_datapath
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [1:0]    req_opcode,
   input  logic [7:0]    req_char_code,
   input  logic [4:0]    req_read_row,
   input  logic [6:0]    req_read_col,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [15:0]   rsp_cell_value,
   output logic [4:0]    rsp_cur_row,
   output logic [6:0]    rsp_cur_col,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int CELL_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam logic [CELL_W-1:0] COLS_C     = CELL_W'(COLUMNS);
   localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(CELL_COUNT - 1);
   localparam logic [CELL_W-1:0] LAST_COPY  = CELL_W'(CELL_COUNT - COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);

   logic [15:0] screen_mem [CELL_COUNT];

   logic [7:0]        attr_ff,    attr_in;
   opcode_type        op_ff,      op_in;
   logic [7:0]        char_ff,    char_in;
   logic [4:0]        rrow_ff,    rrow_in;
   logic [6:0]        rcol_ff,    rcol_in;
   logic [ROW_W-1:0]  row_ff,     row_in;
   logic [COL_W-1:0]  col_ff,     col_in;
   logic [CELL_W-1:0] sweep_ff,   sweep_in;
   logic [2:0]        tab_cnt_ff, tab_cnt_in;
   logic              copy_pend_ff, copy_pend_in;
   logic [CELL_W-1:0] copy_dst_ff,  copy_dst_in;
   logic [15:0]       rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_cell_ff,  rsp_cell_in;
   logic [4:0]        rsp_row_ff,   rsp_row_in;
   logic [6:0]        rsp_col_ff,   rsp_col_in;

   logic              cmd_wr;
   logic [CELL_W-1:0] cmd_addr;
   logic [15:0]       cmd_data;
   logic              wr_en;
   logic [CELL_W-1:0] wr_addr;
   logic [15:0]       wr_data;
   logic [CELL_W-1:0] rd_addr;
   logic [CELL_W-1:0] cursor_addr;
   logic [CELL_W-1:0] read_addr;
   logic              read_in_range;
   logic              wrap;
   logic              row_last;
   logic [15:0]       blank;
   char_kind_type     kind;

   assign cursor_addr   = CELL_W'(row_ff) * COLS_C + CELL_W'(col_ff);
   assign read_addr     = CELL_W'(rrow_ff) * COLS_C + CELL_W'(rcol_ff);
   assign read_in_range = (32'(rrow_ff) < ROWS) && (32'(rcol_ff) < COLUMNS);
   assign wrap          = (col_ff == LAST_COL);
   assign row_last      = (row_ff == LAST_ROW);
   assign blank         = {attr_ff, CH_SPACE};

   always_comb begin
      unique case (char_ff)
         CH_NEWLINE: kind = CK_NEWLINE;
         CH_RETURN:  kind = CK_RETURN;
         CH_TAB:     kind = CK_TAB;
         CH_BACK:    kind = CK_BACK;
         default:    kind = CK_PLAIN;
      endcase
   end

   assign status.opcode     = op_ff;
   assign status.kind       = kind;
   assign status.wrap       = wrap;
   assign status.row_last   = row_last;
   assign status.sweep_last = (sweep_ff == LAST_CELL);
   assign status.copy_last  = (sweep_ff == LAST_COPY);
   assign status.tab_last   = (tab_cnt_ff == 3'd1);
   assign status.tab_zero   = (tab_cnt_ff == 3'd0);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      attr_in      = attr_ff;
      if (psel && penable && pwrite && !paddr[2]) attr_in = pwdata[7:0];
   end

   assign prdata = paddr[2] ? 32'd0 : {24'd0, attr_ff};
   assign pready = 1'b1;

   always_comb begin
      op_in        = op_ff;
      char_in      = char_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      sweep_in     = sweep_ff;
      tab_cnt_in   = tab_cnt_ff;
      copy_pend_in = 1'b0;
      copy_dst_in  = copy_dst_ff;
      cmd_wr       = 1'b0;
      cmd_addr     = cursor_addr;
      cmd_data     = blank;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in  = rsp_cell_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      unique case (cmd.op) inside
         DP_IDLE: ;
         DP_CAPTURE: begin
            op_in      = opcode_type'(req_opcode);
            char_in    = req_char_code;
            rrow_in    = req_read_row;
            rcol_in    = req_read_col;
            sweep_in   = '0;
            tab_cnt_in = TAB_STOP - {1'b0, col_ff[1:0]};
         end
         DP_INIT: begin
            cmd_wr   = 1'b1;
            cmd_addr = sweep_ff;
            cmd_data = INIT_CELL;
            sweep_in = sweep_ff + 1'b1;
         end
         DP_PLAIN_CHAR, DP_PLAIN_SPACE: begin
            cmd_wr   = 1'b1;
            cmd_data = {attr_ff, (cmd.op == DP_PLAIN_SPACE) ? CH_SPACE : char_ff};
            if (cmd.op == DP_PLAIN_SPACE) tab_cnt_in = tab_cnt_ff - 1'b1;
            sweep_in = '0;
            if (wrap) begin
               col_in = '0;
               if (!row_last) row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         DP_BACK: begin
            if (col_ff != '0) begin
               col_in   = col_ff - 1'b1;
               cmd_wr   = 1'b1;
               cmd_addr = cursor_addr - 1'b1;
            end
         end
         DP_RETURN: col_in = '0;
         DP_NEWROW: begin
            col_in   = '0;
            sweep_in = '0;
            if (!row_last) row_in = row_ff + 1'b1;
         end
         DP_COPY: begin
            // read the row below now, write it one row up next cycle
            copy_pend_in = 1'b1;
            copy_dst_in  = sweep_ff;
            sweep_in     = sweep_ff + 1'b1;
         end
         DP_DRAIN: ;
         DP_FILL: begin
            cmd_wr   = 1'b1;
            cmd_addr = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
         end
         DP_CLEAR: begin
            cmd_wr   = 1'b1;
            cmd_addr = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            row_in   = '0;
            col_in   = '0;
         end
         DP_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_cell_in  = (op_ff == OP_READ && read_in_range) ? rd_data_ff : 16'd0;
            rsp_row_in   = 5'(row_ff);
            rsp_col_in   = 7'(col_ff);
         end
         default: ;
      endcase
   end

   // a pending scroll copy owns the write port
   assign wr_en   = copy_pend_ff || cmd_wr;
   assign wr_addr = copy_pend_ff ? copy_dst_ff : cmd_addr;
   assign wr_data = copy_pend_ff ? rd_data_ff  : cmd_data;
   assign rd_addr = (cmd.op == DP_COPY) ? (sweep_ff + COLS_C)
                                        : (read_in_range ? read_addr : '0);

   always_ff @(posedge clock) begin
      if (wr_en) screen_mem[wr_addr] <= wr_data;
      rd_data_ff <= screen_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         sweep_ff     <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sweep_ff     <= sweep_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      char_ff     <= char_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      tab_cnt_ff  <= tab_cnt_in;
      copy_dst_ff <= copy_dst_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_cell_ff;
   assign rsp_cur_row    = rsp_row_ff;
   assign rsp_cur_col    = rsp_col_ff;

endmodule

@@ design/text_console_cursor_engine_unit.sv @@
`timescale 1ns / 1ps

// Text console engine: a ROWS x COLUMNS screen of 16-bit cells (attribute high, character
// low) in a single-port-write, registered-read memory, plus a cursor. Each request word
// gives exactly one response word with the cell read (zero unless reading) and the cursor
// after the operation. Unless it scrolls, a put of an ordinary character, return,
// backspace or newline, a read, and an unused opcode pass through capture, dispatch and
// finish to the response register, finish waiting while the held response is stalled; a
// tab writes its 1 to 4 spaces one per step from dispatch on. The screen memory moves one
// cell per cycle, which sets the long cases: a scroll runs a copy, a drain step and a
// blank fill of the bottom row, and a clear sweeps every cell. After reset a clearing
// pass over all ROWS*COLUMNS cells fills the screen with 0x0720 while requests are
// stalled; attribute writes are taken at any time. One request is worked at a time; a
// finished response waits in its own register while the next request is accepted.
module text_console_cursor_engine_unit
   import tcce_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_cell_value,
   output logic [4:0]  rsp_cur_row,
   output logic [6:0]  rsp_cur_col,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   dp_cmd_type    cmd;
   dp_status_type status;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcce_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cur_row    (rsp_cur_row),
      .rsp_cur_col    (rsp_cur_col),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

endmodule

@@ design/tcce_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcce_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_cell_value,
   input logic [4:0]  rsp_cur_row,
   input logic [6:0]  rsp_cur_col
);

   // hold a stalled response word
   `TCCE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_value) && $stable(rsp_cur_row) && $stable(rsp_cur_col), "response word changed while stalled")

   `TCCE_ASSERT(a_col_range, clock, reset, rsp_valid |-> (32'(rsp_cur_col) < COLUMNS), "cursor column beyond line end")

   `TCCE_ASSERT(a_row_range, clock, reset, rsp_valid |-> (32'(rsp_cur_row) < ROWS), "cursor row beyond last row")

   // one word at a time: busy right after an accept
   `TCCE_ASSERT(a_busy_after_accept, clock, reset, req_valid && !req_stall |=> req_stall, "request accepted while busy")

   // the clearing pass follows reset
   `TCCE_ASSERT_ALWAYS(a_stall_after_reset, clock, $past(reset) |-> req_stall, "request taken before screen cleared")

endmodule

bind text_console_cursor_engine_unit tcce_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcce_checker (.*);

@@ tb/sv/text_console_cursor_engine_unit_test.sv @@
`timescale 1ns / 1ps

module text_console_cursor_engine_unit_test;
   import tcce_pkg::*;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int CELLS         = ROWS * COLUMNS;
   localparam int CYCLE_LIMIT   = 16_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int REPORT_LIMIT  = 10;
   localparam int SETTLE_CYCLES = 50;

   localparam logic [2:0] ADDR_ATTRIBUTE = 3'd0;
   localparam logic [2:0] ADDR_UNUSED    = 3'd4;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [4:0]  cur_row;
      logic [6:0]  cur_col;
   } console_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_NONE;
   logic [7:0]  req_char_code = '0;
   logic [4:0]  req_read_row = '0;
   logic [6:0]  req_read_col = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_cell_value;
   logic [4:0]  rsp_cur_row;
   logic [6:0]  rsp_cur_col;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // screen and cursor as the block should hold them
   logic [15:0] screen_model [CELLS];
   int          model_row = 0;
   int          model_col = 0;
   logic [7:0]  attr_shadow = ATTR_RESET;

   console_rsp_type expected_rsp [$];

   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   bit hold_request  = 1'b0;
   int items_sent    = 0;
   int results_seen  = 0;
   int mismatches    = 0;
   int scrolls_seen  = 0;
   int clears_seen   = 0;
   int cycle_count   = 0;

   text_console_cursor_engine_unit #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cell_value(rsp_cell_value),
      .rsp_cur_row   (rsp_cur_row),
      .rsp_cur_col   (rsp_cur_col),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] blank_cell();
      return {attr_shadow, CH_SPACE};
   endfunction

   function automatic void next_row();
      int r;
      int c;
      model_col = 0;
      model_row++;
      if (model_row >= ROWS) begin
         for (r = 1; r < ROWS; r++)
            for (c = 0; c < COLUMNS; c++)
               screen_model[(r - 1) * COLUMNS + c] = screen_model[r * COLUMNS + c];
         for (c = 0; c < COLUMNS; c++)
            screen_model[(ROWS - 1) * COLUMNS + c] = blank_cell();
         model_row = ROWS - 1;
         scrolls_seen++;
      end
   endfunction

   function automatic void write_plain(logic [7:0] ch);
      screen_model[model_row * COLUMNS + model_col] = {attr_shadow, ch};
      model_col++;
      if (model_col >= COLUMNS)
         next_row();
   endfunction

   function automatic void put_character(logic [7:0] ch);
      int spaces;
      if (ch == CH_NEWLINE) begin
         next_row();
      end else if (ch == CH_RETURN) begin
         model_col = 0;
      end else if (ch == CH_TAB) begin
         // fix the count first: the line may wrap on the last space
         spaces = int'(TAB_STOP) - (model_col % int'(TAB_STOP));
         repeat (spaces) write_plain(CH_SPACE);
      end else if (ch == CH_BACK) begin
         if (model_col > 0) begin
            model_col--;
            screen_model[model_row * COLUMNS + model_col] = blank_cell();
         end
      end else begin
         write_plain(ch);
      end
   endfunction

   function automatic console_rsp_type console_apply(opcode_type op, logic [7:0] ch,
                                                     logic [4:0] rr, logic [6:0] rc);
      console_rsp_type result;
      int i;
      result.cell_value = '0;
      case (op)
         OP_PUT: begin
            put_character(ch);
         end
         OP_READ: begin
            if (rr < ROWS && rc < COLUMNS)
               result.cell_value = screen_model[rr * COLUMNS + rc];
         end
         OP_CLEAR: begin
            for (i = 0; i < CELLS; i++)
               screen_model[i] = blank_cell();
            model_row = 0;
            model_col = 0;
            clears_seen++;
         end
         default: begin
         end
      endcase
      result.cur_row = model_row[4:0];
      result.cur_col = model_col[6:0];
      return result;
   endfunction

   // check the result word first, then log the request word taken at this edge
   always @(posedge clock) begin
      console_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected response: cell %h row %0d col %0d",
                           rsp_cell_value, rsp_cur_row, rsp_cur_col);
            end else begin
               want = expected_rsp.pop_front();
               if (want.cell_value !== rsp_cell_value || want.cur_row !== rsp_cur_row ||
                   want.cur_col !== rsp_cur_col) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("response %0d mismatch: expected cell %h row %0d col %0d, %s",
                              results_seen, want.cell_value, want.cur_row, want.cur_col,
                              $sformatf("got cell %h row %0d col %0d",
                                        rsp_cell_value, rsp_cur_row, rsp_cur_col));
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr == ADDR_ATTRIBUTE)
            attr_shadow = pwdata[7:0];
         if (req_valid && !req_stall)
            expected_rsp.push_back(console_apply(opcode_type'(req_opcode), req_char_code,
                                                 req_read_row, req_read_col));
      end
   end

   // receiver: random stall, or a long hold when asked
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, items_sent - results_seen);
         $display("text_console_cursor_engine_unit regression: fail");
         $finish;
      end
   end

   task automatic send_word(input opcode_type op, input logic [7:0] ch,
                            input logic [4:0] rr, input logic [6:0] rc);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_char_code <= ch;
      req_read_row  <= rr;
      req_read_col  <= rc;
      // hold the word until it is taken
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic wait_drained();
      // drop the last word so it is not taken again
      req_valid <= 1'b0;
      while (results_seen < items_sent)
         @(posedge clock);
   endtask

   task automatic csr_write_and_check(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_ATTRIBUTE;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== attr_shadow) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("attribute readback mismatch: expected %h, got %h",
                     attr_shadow, prdata[7:0]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_random_word();
      int         pick;
      int         sel;
      opcode_type op;
      logic [7:0] ch;
      logic [4:0] rr;
      logic [6:0] rc;
      ch = 8'($urandom_range(255));
      rr = 5'($urandom_range(31));
      rc = 7'($urandom_range(127));
      pick = $urandom_range(999);
      if (pick < 4) begin
         op = OP_CLEAR;
      end else if (pick < 24) begin
         op = OP_NONE;
      end else if (pick < 274) begin
         op = OP_READ;
         sel = $urandom_range(9);
         if (sel < 4) begin
            rr = model_row[4:0];
            rc = 7'($urandom_range(COLUMNS - 1));
         end else if (sel < 8) begin
            rr = 5'($urandom_range(ROWS - 1));
            rc = 7'($urandom_range(COLUMNS - 1));
         end
      end else begin
         op = OP_PUT;
         sel = $urandom_range(99);
         if (sel < 12)
            ch = CH_NEWLINE;
         else if (sel < 15)
            ch = CH_RETURN;
         else if (sel < 21)
            ch = CH_TAB;
         else if (sel < 28)
            ch = CH_BACK;
         else if (sel < 43)
            ch = CH_SPACE;
         else if (sel < 95)
            ch = 8'($urandom_range(8'h7E, 8'h21));
      end
      send_word(op, ch, rr, rc);
   endtask

   task automatic test_directed();
      send_word(OP_READ, 8'h00, 5'd0, 7'd0);
      send_word(OP_READ, 8'h00, 5'd24, 7'd79);
      send_word(OP_READ, 8'h00, 5'd25, 7'd0);
      send_word(OP_READ, 8'h00, 5'd0, 7'd80);
      send_word(OP_READ, 8'hFF, 5'd31, 7'd127);
      send_word(OP_NONE, 8'hFF, 5'd31, 7'd127);
      wait_drained();
      csr_write_and_check(ADDR_UNUSED, 32'hFFFF_FF3C);
      csr_write_and_check(ADDR_ATTRIBUTE, 32'h0000_0000);
      send_word(OP_PUT, 8'h41, 5'd0, 7'd0);
      send_word(OP_PUT, 8'h00, 5'd0, 7'd0);
      send_word(OP_PUT, 8'hFF, 5'd0, 7'd0);
      send_word(OP_PUT, CH_BACK, 5'd0, 7'd0);
      send_word(OP_PUT, CH_RETURN, 5'd0, 7'd0);
      // backspace in the first column does nothing
      send_word(OP_PUT, CH_BACK, 5'd0, 7'd0);
      send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
      send_word(OP_PUT, 8'h78, 5'd0, 7'd0);
      send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
      send_word(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);
      send_word(OP_READ, 8'h00, 5'd0, 7'd0);
      send_word(OP_READ, 8'h00, 5'd0, 7'd1);
      send_word(OP_READ, 8'h00, 5'd0, 7'd2);
      send_word(OP_READ, 8'h00, 5'd0, 7'd4);
      send_word(OP_READ, 8'h00, 5'd0, 7'd7);
      send_word(OP_CLEAR, 8'h00, 5'd0, 7'd0);
      send_word(OP_READ, 8'h00, 5'd0, 7'd0);
   endtask

   task automatic test_wrap_and_scroll();
      int i;
      send_word(OP_CLEAR, 8'h00, 5'd0, 7'd0);
      // one marked line per row, enough to scroll twice
      for (i = 0; i < ROWS + 1; i++) begin
         send_word(OP_PUT, 8'(8'h61 + i), 5'd0, 7'd0);
         send_word(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);
      end
      for (i = 0; i < COLUMNS / int'(TAB_STOP) - 1; i++)
         send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
      send_word(OP_PUT, 8'h79, 5'd0, 7'd0);
      send_word(OP_PUT, 8'h7A, 5'd0, 7'd0);
      // tab off the end of the bottom row wraps and scrolls
      send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
      send_word(OP_PUT, CH_BACK, 5'd0, 7'd0);
      for (i = 76; i < COLUMNS; i++)
         send_word(OP_READ, 8'h00, 5'(ROWS - 2), 7'(i));
      send_word(OP_READ, 8'h00, 5'(ROWS - 1), 7'd0);
      send_word(OP_READ, 8'h00, 5'(ROWS - 3), 7'd0);
      send_word(OP_READ, 8'h00, 5'd0, 7'd0);
      // a full line of plain characters wraps at the last column
      for (i = 0; i < COLUMNS; i++)
         send_word(OP_PUT, 8'(8'h30 + (i % 10)), 5'd0, 7'd0);
      send_word(OP_READ, 8'h00, 5'(ROWS - 2), 7'(COLUMNS - 1));
   endtask

   task automatic test_backpressure();
      int i;
      idle_pct = 0;
      stall_pct = 0;
      hold_request = 1'b1;
      for (i = 0; i < 24; i++)
         send_random_word();
      // pause the sender until everything is back
      wait_drained();
      for (i = 0; i < 8; i++)
         send_random_word();
   endtask

   task automatic test_random_phase(input int sender_idle, input int receiver_stall,
                                    input int count);
      int i;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      for (i = 0; i < count; i++)
         send_random_word();
   endtask

   initial begin
      int i;
      for (i = 0; i < CELLS; i++)
         screen_model[i] = INIT_CELL;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      wait_drained();
      csr_write_and_check(ADDR_ATTRIBUTE, 32'h0000_00FF);
      test_wrap_and_scroll();
      wait_drained();
      test_backpressure();
      wait_drained();
      csr_write_and_check(ADDR_ATTRIBUTE, 32'($urandom_range(255)));
      test_random_phase(0, 0, 260);
      wait_drained();
      csr_write_and_check(ADDR_ATTRIBUTE, 32'h0000_0000);
      test_random_phase(60, 0, 260);
      wait_drained();
      csr_write_and_check(ADDR_ATTRIBUTE, 32'h0000_00FF);
      test_random_phase(0, 60, 260);
      wait_drained();
      csr_write_and_check(ADDR_ATTRIBUTE, 32'($urandom_range(255)));
      test_random_phase(15, 15, 260);
      wait_drained();
      stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d request words sent, %0d response words checked, %0d mismatches",
               items_sent, results_seen, mismatches);
      $display("screen model saw %0d scrolls and %0d clears in %0d cycles",
               scrolls_seen, clears_seen, cycle_count);
      if (mismatches == 0 && expected_rsp.size() == 0 && results_seen == items_sent)
         $display("text_console_cursor_engine_unit regression: pass");
      else
         $display("text_console_cursor_engine_unit regression: fail");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/tcce_pkg.sv
design/tcce_ctrl.sv
design/tcce_datapath.sv
design/text_console_cursor_engine_unit.sv
design/tcce_checker.sv
tb/sv/text_console_cursor_engine_unit_test.sv
